>>> hw/rtl/fqpd_pkg.sv
// shared types and constants of the flit queue with packet drop
package fqpd_pkg;

   localparam int DEPTH_DEFAULT        = 64;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 3;

   localparam logic [1:0] KIND_HEAD = 2'd0;
   localparam logic [1:0] KIND_TAIL = 2'd2;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] id;
      logic [7:0]  count;
      logic [7:0]  seq;
   } header_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic head_match;
      logic tail;
   } cell_flags_type;

   typedef struct packed {
      logic load;
      logic step;
   } tree_cmd_type;

endpackage

>>> hw/rtl/fqpd_cell.sv
// one flit slot of the queue chain with its local compare
module fqpd_cell #(
   parameter int PAYLOAD_BITS = fqpd_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  fqpd_pkg::cell_ctrl_type    ctrl,
   input  fqpd_pkg::header_type       load_hdr,
   input  logic [PAYLOAD_BITS-1:0]    load_pay,
   input  fqpd_pkg::header_type       next_hdr,
   input  logic [PAYLOAD_BITS-1:0]    next_pay,
   input  logic [15:0]                key,
   output fqpd_pkg::header_type       hdr,
   output logic [PAYLOAD_BITS-1:0]    pay,
   output fqpd_pkg::cell_flags_type   flags
);
   import fqpd_pkg::*;

   header_type              hdr_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         hdr_ff <= load_hdr;
         pay_ff <= load_pay;
      end else if (ctrl.shift) begin
         hdr_ff <= next_hdr;
         pay_ff <= next_pay;
      end
   end

   assign hdr              = hdr_ff;
   assign pay              = pay_ff;
   assign flags.head_match = (hdr_ff.kind == KIND_HEAD) && (hdr_ff.id == key);
   assign flags.tail       = (hdr_ff.kind == KIND_TAIL);

endmodule

>>> hw/rtl/fqpd_tree.sv
// registered first-hit search, halving the candidates every cycle that step is asserted
module fqpd_tree #(
   parameter int DEPTH = fqpd_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  fqpd_pkg::tree_cmd_type     cmd,
   input  logic [DEPTH-1:0]           leaf_hit,
   input  logic [7:0]                 leaf_count [DEPTH],
   output logic                       hit,
   output logic [$clog2(DEPTH)-1:0]   index,
   output logic [7:0]                 count
);
   import fqpd_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TSIZE  = 1 << ADDR_W;
   localparam int HALF   = TSIZE / 2;

   logic              hit_ff [TSIZE];
   logic [ADDR_W-1:0] idx_ff [TSIZE];
   logic [7:0]        cnt_ff [TSIZE];

   for (genvar g = 0; g < TSIZE; g++) begin : g_node
      logic              load_hit;
      logic [7:0]        load_cnt;
      logic              step_hit;
      logic [ADDR_W-1:0] step_idx;
      logic [7:0]        step_cnt;

      if (g < DEPTH) begin : g_leaf
         assign load_hit = leaf_hit[g];
         assign load_cnt = leaf_count[g];
      end else begin : g_pad
         assign load_hit = 1'b0;
         assign load_cnt = 8'd0;
      end

      if (g < HALF) begin : g_pair
         assign step_hit = hit_ff[2*g] | hit_ff[2*g+1];
         assign step_idx = hit_ff[2*g] ? idx_ff[2*g] : idx_ff[2*g+1];
         assign step_cnt = hit_ff[2*g] ? cnt_ff[2*g] : cnt_ff[2*g+1];
      end else begin : g_hold
         assign step_hit = hit_ff[g];
         assign step_idx = idx_ff[g];
         assign step_cnt = cnt_ff[g];
      end

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            hit_ff[g] <= load_hit;
            idx_ff[g] <= ADDR_W'(g);
            cnt_ff[g] <= load_cnt;
         end else if (cmd.step) begin
            hit_ff[g] <= step_hit;
            idx_ff[g] <= step_idx;
            cnt_ff[g] <= step_cnt;
         end
      end
   end

   assign hit   = hit_ff[0];
   assign index = idx_ff[0];
   assign count = cnt_ff[0];

endmodule

>>> hw/rtl/flit_queue_with_packet_drop_core.sv
// flit queue with packet drop: chain of flit cells, search tree and sequencer
// push and pop: request registered, then executed and result registered in S_EXEC
// find: a head search through the registered search tree, then a reply from S_REPLY
// remove: head search, tail search, then the packet's flits erased one chain shift a cycle
// one transaction in flight; a new one is taken while the last result waits
// synchronous active-high reset empties the queue and drops any pending result
module flit_queue_with_packet_drop_core #(
   parameter int DEPTH        = fqpd_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_BITS = fqpd_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // packet_id, flit_count, sequence_req, payload
   input  logic [fqpd_pkg::REQ_DATA_W-1:0] req_tdata,
   // action, flit_kind
   input  logic [fqpd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // match_index, removed_count, out_packet_id, out_flit_count, out_sequence,
   // out_payload, occupancy, zero pad
   output logic [fqpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // ok, out_kind
   output logic [fqpd_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import fqpd_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int STEP_W = $clog2(ADDR_W + 1);
   localparam int E_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEEK_HEAD,
      S_SEEK_TAIL,
      S_ERASE,
      S_REPLY
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        fill_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CNT_W-1:0]        shift_ff;
   logic                    hit_ff;
   logic [ADDR_W-1:0]       pos_ff;
   logic [7:0]              num_ff;

   action_type              act_ff;
   header_type              req_hdr_ff;
   logic [PAYLOAD_BITS-1:0] req_pay_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_ok_ff;
   logic [1:0]              rsp_kind_ff;
   logic [5:0]              rsp_idx_ff;
   logic [7:0]              rsp_rcount_ff;
   logic [15:0]             rsp_id_ff;
   logic [7:0]              rsp_fcount_ff;
   logic [7:0]              rsp_seq_ff;
   logic [31:0]             rsp_pay_ff;
   logic [6:0]              rsp_occ_ff;

   header_type              cell_hdr   [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_pay   [DEPTH];
   cell_flags_type          cell_flags [DEPTH];
   cell_ctrl_type           cell_ctrl  [DEPTH];
   logic [7:0]              leaf_count [DEPTH];
   logic [DEPTH-1:0]        leaf_head;
   logic [DEPTH-1:0]        leaf_tail;

   tree_cmd_type            tree_cmd;
   logic                    tree_hit;
   logic [ADDR_W-1:0]       tree_index;
   logic [7:0]              tree_count;

   logic                    out_free;
   logic                    rsp_load;
   logic                    seek_done;
   logic                    is_search;
   logic                    full;
   logic                    empty;
   logic                    do_push;
   logic                    do_pop;
   logic                    do_erase;
   logic [PAYLOAD_BITS+31:0] req_pay_wide;
   logic [PAYLOAD_BITS+31:0] pop_pay_wide;
   logic [CNT_W+6:0]        occ_wide_in;
   logic [CNT_W+6:0]        occ_wide_ff;
   logic [ADDR_W+5:0]       idx_wide;
   logic [CNT_W-1:0]        fill_in;
   logic [E_W-1:0]          lim_count;
   logic [E_W-1:0]          lim_tail;
   logic [E_W-1:0]          lim_fill;
   logic [E_W-1:0]          erase_end;
   logic [CNT_W-1:0]        shift_in;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign seek_done = (step_ff == STEP_W'(ADDR_W));
   assign is_search = (act_ff == ACT_FIND) || (act_ff == ACT_REMOVE);
   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign do_push   = (state_ff == S_EXEC) && out_free && (act_ff == ACT_PUSH) && !full;
   assign do_pop    = (state_ff == S_EXEC) && out_free && (act_ff == ACT_POP) && !empty;
   assign do_erase  = (state_ff == S_ERASE) && (shift_ff != '0);
   assign rsp_load  = out_free && (((state_ff == S_EXEC) && !is_search) ||
                                   (state_ff == S_REPLY));

   always_comb begin
      fill_in = fill_ff;
      if (do_push) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   assign req_pay_wide = {{PAYLOAD_BITS{1'b0}}, req_tdata[63:32]};
   assign pop_pay_wide = {32'd0, cell_pay[0]};
   assign occ_wide_in  = {7'd0, fill_in};
   assign occ_wide_ff  = {7'd0, fill_ff};
   assign idx_wide     = {6'd0, pos_ff};

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      header_type              nhdr;
      logic [PAYLOAD_BITS-1:0] npay;
      logic                    occupied;

      if (i == DEPTH - 1) begin : g_last
         assign nhdr = cell_hdr[i];
         assign npay = cell_pay[i];
      end else begin : g_inner
         assign nhdr = cell_hdr[i+1];
         assign npay = cell_pay[i+1];
      end

      assign occupied           = (CNT_W'(i) < fill_ff);
      assign cell_ctrl[i].load  = do_push && (fill_ff == CNT_W'(i));
      assign cell_ctrl[i].shift = do_pop || (do_erase && (ADDR_W'(i) >= pos_ff));
      assign leaf_head[i]       = occupied && cell_flags[i].head_match;
      assign leaf_tail[i]       = occupied && cell_flags[i].tail &&
                                  (ADDR_W'(i) >= tree_index);
      assign leaf_count[i]      = cell_hdr[i].count;

      fqpd_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .load_hdr (req_hdr_ff),
         .load_pay (req_pay_ff),
         .next_hdr (nhdr),
         .next_pay (npay),
         .key      (req_hdr_ff.id),
         .hdr      (cell_hdr[i]),
         .pay      (cell_pay[i]),
         .flags    (cell_flags[i])
      );
   end

   // search tree
   assign tree_cmd.load = ((state_ff == S_EXEC) && is_search) ||
                          ((state_ff == S_SEEK_HEAD) && seek_done &&
                           (act_ff == ACT_REMOVE) && tree_hit);
   assign tree_cmd.step = ((state_ff == S_SEEK_HEAD) || (state_ff == S_SEEK_TAIL)) &&
                          !seek_done;

   fqpd_tree #(
      .DEPTH (DEPTH)
   ) u_tree (
      .clock      (clock),
      .cmd        (tree_cmd),
      .leaf_hit   ((state_ff == S_EXEC) ? leaf_head : leaf_tail),
      .leaf_count (leaf_count),
      .hit        (tree_hit),
      .index      (tree_index),
      .count      (tree_count)
   );

   // end of the erased run
   always_comb begin
      lim_count = E_W'(pos_ff) + E_W'(num_ff);
      lim_fill  = E_W'(fill_ff);
      lim_tail  = tree_hit ? (E_W'(tree_index) + E_W'(1)) : lim_fill;
      erase_end = lim_count;
      if (lim_tail < erase_end) begin
         erase_end = lim_tail;
      end
      if (lim_fill < erase_end) begin
         erase_end = lim_fill;
      end
      shift_in = CNT_W'(erase_end - E_W'(pos_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  act_ff           <= action_type'(req_tuser[1:0]);
                  req_hdr_ff.kind  <= req_tuser[3:2];
                  req_hdr_ff.id    <= req_tdata[15:0];
                  req_hdr_ff.count <= req_tdata[23:16];
                  req_hdr_ff.seq   <= req_tdata[31:24];
                  req_pay_ff       <= req_pay_wide[PAYLOAD_BITS-1:0];
                  state_ff         <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (is_search) begin
                  step_ff  <= '0;
                  state_ff <= S_SEEK_HEAD;
               end else if (out_free) begin
                  rsp_ok_ff     <= do_push || do_pop;
                  rsp_idx_ff    <= 6'd0;
                  rsp_rcount_ff <= 8'd0;
                  rsp_kind_ff   <= do_pop ? cell_hdr[0].kind : 2'd0;
                  rsp_id_ff     <= do_pop ? cell_hdr[0].id : 16'd0;
                  rsp_fcount_ff <= do_pop ? cell_hdr[0].count : 8'd0;
                  rsp_seq_ff    <= do_pop ? cell_hdr[0].seq : 8'd0;
                  rsp_pay_ff    <= do_pop ? pop_pay_wide[31:0] : 32'd0;
                  rsp_occ_ff    <= occ_wide_in[6:0];
                  fill_ff       <= fill_in;
                  state_ff      <= S_IDLE;
               end
            end
            S_SEEK_HEAD: begin
               if (!seek_done) begin
                  step_ff <= step_ff + STEP_W'(1);
               end else begin
                  hit_ff <= tree_hit;
                  pos_ff <= tree_hit ? tree_index : '0;
                  num_ff <= tree_hit ? tree_count : 8'd0;
                  if ((act_ff == ACT_REMOVE) && tree_hit) begin
                     step_ff  <= '0;
                     state_ff <= S_SEEK_TAIL;
                  end else begin
                     state_ff <= S_REPLY;
                  end
               end
            end
            S_SEEK_TAIL: begin
               if (!seek_done) begin
                  step_ff <= step_ff + STEP_W'(1);
               end else begin
                  shift_ff <= shift_in;
                  state_ff <= S_ERASE;
               end
            end
            S_ERASE: begin
               if (do_erase) begin
                  shift_ff <= shift_ff - CNT_W'(1);
                  fill_ff  <= fill_ff - CNT_W'(1);
               end else begin
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               if (out_free) begin
                  rsp_ok_ff     <= hit_ff;
                  rsp_idx_ff    <= idx_wide[5:0];
                  rsp_rcount_ff <= num_ff;
                  rsp_kind_ff   <= 2'd0;
                  rsp_id_ff     <= 16'd0;
                  rsp_fcount_ff <= 8'd0;
                  rsp_seq_ff    <= 8'd0;
                  rsp_pay_ff    <= 32'd0;
                  rsp_occ_ff    <= occ_wide_ff[6:0];
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_kind_ff, rsp_ok_ff};
   assign rsp_tdata  = {3'd0, rsp_occ_ff, rsp_pay_ff, rsp_seq_ff, rsp_fcount_ff,
                        rsp_id_ff, rsp_rcount_ff, rsp_idx_ff};

endmodule
